[rtl/tncs_pkg.sv]
// ----------------------------------------------------------------------------
// tncs_pkg
// Types and constants shared by the three node counter sync block.
// ----------------------------------------------------------------------------
`default_nettype none

package tncs_pkg;

  localparam int unsigned QDEPTH = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_FAST_SYNC      = 3'd0;
  localparam logic [2:0] CFG_TOO_SLOW_LIMIT = 3'd1;
  localparam logic [2:0] CFG_RECOVER_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_INITIAL_ID     = 3'd3;
  localparam logic [2:0] CFG_INITIAL_COUNT  = 3'd4;

  // input mode codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_MSG1  = 2'd1;
  localparam logic [1:0] MODE_MSG2  = 2'd2;

  localparam logic [31:0] NONE_ID = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    K_TICK = 2'd0,
    K_MSG1 = 2'd1,
    K_MSG2 = 2'd2,
    K_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] peer_id;
    logic [31:0] peer_count;
  } item_t;

  typedef struct packed {
    logic        send_first;
    logic        send_second;
    logic [31:0] sent_id;
    logic [31:0] sent_count;
    logic [31:0] own_id;
    logic [31:0] own_count;
    logic        fast_from_first;
    logic        slow_from_first;
    logic        fast_from_second;
    logic        slow_from_second;
    logic        slow_to_first;
    logic        slow_to_second;
  } result_t;

  // handshake between a producer and a queue
  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

endpackage

`default_nettype wire

[rtl/tncs_fifo.sv]
// ----------------------------------------------------------------------------
// tncs_fifo
// Small first-word-fall-through queue of QDEPTH entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tncs_fifo #(
  parameter int unsigned W = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  import tncs_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QDEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

[rtl/tncs_front.sv]
// ----------------------------------------------------------------------------
// tncs_front
// Accepts input transactions and classifies them into tick, peer one or peer two message, or none.
// ----------------------------------------------------------------------------
`default_nettype none

module tncs_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire logic [1:0]      in_mode,
  input  wire logic [31:0]     in_peer_id,
  input  wire logic [31:0]     in_peer_count,
  output tncs_pkg::qwr_t       q_wr,
  input  wire logic            q_full,
  output tncs_pkg::item_t      q_item
);
  import tncs_pkg::*;

  logic  v_r, v_nxt;
  item_t item_r;
  kind_t kind;
  logic  take;

  always_comb begin
    case (in_mode)
      MODE_TICK: kind = K_TICK;
      MODE_MSG1: kind = K_MSG1;
      MODE_MSG2: kind = K_MSG2;
      default:   kind = K_NONE;
    endcase
  end

  assign in_full = v_r && q_full;
  assign take    = in_push && !in_full;
  assign v_nxt   = take || (v_r && q_full);

  assign q_wr.push = v_r;
  assign q_wr.full = q_full;
  assign q_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{kind: kind, peer_id: in_peer_id, peer_count: in_peer_count};
    end
  end

endmodule

`default_nettype wire

[rtl/tncs_back.sv]
// ----------------------------------------------------------------------------
// tncs_back
// Carries out classified items: send scheduling, peer monitoring, adoption.
// ----------------------------------------------------------------------------
`default_nettype none

module tncs_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [31:0]     cfg_data,
  input  wire logic            q_empty,
  input  tncs_pkg::item_t      q_item,
  output logic                 q_pop,
  output tncs_pkg::qwr_t       o_wr,
  input  wire logic            o_full,
  output tncs_pkg::result_t    o_res
);
  import tncs_pkg::*;

  logic        fast_sync_r;
  logic [9:0]  slow_lim_r, rec_lim_r;

  logic [31:0] tick_r, tick_nxt;
  logic [3:0]  r10_r, r10_nxt;
  logic [6:0]  r100_r, r100_nxt;
  logic [7:0]  r150_r, r150_nxt;
  logic [31:0] own_id_r, own_id_nxt;
  logic [31:0] own_cnt_r, own_cnt_nxt;
  logic [31:0] p1_id_r, p1_id_nxt, p1_cnt_r, p1_cnt_nxt;
  logic [31:0] p2_id_r, p2_id_nxt, p2_cnt_r, p2_cnt_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [10:0] ivl_r [2];
  logic [10:0] ivl_nxt [2];
  logic [1:0]  rx_fast_r, rx_fast_nxt;
  logic [1:0]  rx_slow_r, rx_slow_nxt;
  logic [1:0]  tx_slow_r, tx_slow_nxt;

  logic        step;
  logic [1:0]  send;
  logic [31:0] ov;
  logic        s1, s2, m1, m2;

  function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a : b;
  endfunction

  assign step      = !q_empty && !o_full;
  assign q_pop     = step;
  assign o_wr.push = step;
  assign o_wr.full = o_full;

  always_comb begin
    tick_nxt    = tick_r;
    r10_nxt     = r10_r;
    r100_nxt    = r100_r;
    r150_nxt    = r150_r;
    own_id_nxt  = own_id_r;
    own_cnt_nxt = own_cnt_r;
    p1_id_nxt   = p1_id_r;
    p1_cnt_nxt  = p1_cnt_r;
    p2_id_nxt   = p2_id_r;
    p2_cnt_nxt  = p2_cnt_r;
    pend_nxt    = pend_r;
    ivl_nxt     = ivl_r;
    rx_fast_nxt = rx_fast_r;
    rx_slow_nxt = rx_slow_r;
    tx_slow_nxt = tx_slow_r;
    send        = 2'b00;
    ov          = own_cnt_r;
    s1          = 1'b0;
    s2          = 1'b0;
    m1          = 1'b0;
    m2          = 1'b0;
    if (step) begin
      case (q_item.kind)
        K_MSG1: begin
          pend_nxt[0] = 1'b1;
          p1_id_nxt   = q_item.peer_id;
          p1_cnt_nxt  = q_item.peer_count;
        end
        K_MSG2: begin
          pend_nxt[1] = 1'b1;
          p2_id_nxt   = q_item.peer_id;
          p2_cnt_nxt  = q_item.peer_count;
        end
        K_TICK: begin
          tick_nxt = tick_r + 32'd1;
          // residues follow the 32-bit counter through its wrap
          if (tick_r == '1) begin
            r10_nxt  = '0;
            r100_nxt = '0;
            r150_nxt = '0;
          end else begin
            r10_nxt  = (r10_r == 4'd9) ? 4'd0 : r10_r + 4'd1;
            r100_nxt = (r100_r == 7'd99) ? 7'd0 : r100_r + 7'd1;
            r150_nxt = (r150_r == 8'd149) ? 8'd0 : r150_r + 8'd1;
          end
          for (int k = 0; k < 2; k++) begin
            send[k] = (tx_slow_r[k] && r150_nxt == 8'd0) ||
                      (!tx_slow_r[k] && !fast_sync_r && r100_nxt == 7'd0) ||
                      (fast_sync_r && r10_nxt == 4'd0);
          end
          if (r100_nxt == 7'd0) begin
            ov = own_cnt_r + 32'd1;
          end
          for (int k = 0; k < 2; k++) begin
            if (pend_r[k]) begin
              pend_nxt[k] = 1'b0;
              if (ivl_r[k] >= 11'd99) begin
                rx_fast_nxt[k] = 1'b0;
              end else if (ivl_r[k] >= 11'd9) begin
                rx_fast_nxt[k] = 1'b1;
              end
              ivl_nxt[k] = '0;
            end else if (ivl_r[k] > {1'b0, slow_lim_r}) begin
              rx_slow_nxt[k] = 1'b1;
            end else begin
              if (ivl_r[k] < {1'b0, rec_lim_r}) begin
                rx_slow_nxt[k] = 1'b0;
              end
              ivl_nxt[k] = ivl_r[k] + 11'd1;
            end
          end
          s1 = rx_slow_nxt[0];
          s2 = rx_slow_nxt[1];
          m1 = (own_id_r == p1_id_r);
          m2 = (own_id_r == p2_id_r);
          own_cnt_nxt = ov;
          // fixed priority: freeze, adopt one, adopt two, merge, adopt shared peer, keep
          if (fast_sync_r) begin
            tx_slow_nxt = 2'b00;
          end else if (rx_fast_nxt[0] && !s1) begin
            own_cnt_nxt = p1_cnt_r;
            own_id_nxt  = p1_id_r;
            tx_slow_nxt = 2'b01;
          end else if (rx_fast_nxt[1] && !s2) begin
            own_cnt_nxt = p2_cnt_r;
            own_id_nxt  = p2_id_r;
            tx_slow_nxt = 2'b10;
          end else if (m1 && m2 && !s1 && !s2) begin
            own_cnt_nxt = max32(ov, max32(p1_cnt_r, p2_cnt_r));
            tx_slow_nxt = 2'b00;
          end else if (m1 && !s1) begin
            own_cnt_nxt = max32(ov, p1_cnt_r);
            tx_slow_nxt = 2'b10;
          end else if (m2 && !s2) begin
            own_cnt_nxt = max32(ov, p2_cnt_r);
            tx_slow_nxt = 2'b01;
          end else if (p1_id_r == p2_id_r && p1_id_r != NONE_ID && !s1 && !s2) begin
            own_id_nxt  = p1_id_r;
            own_cnt_nxt = max32(p1_cnt_r, p2_cnt_r);
            tx_slow_nxt = 2'b11;
          end else begin
            tx_slow_nxt = 2'b11;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    o_res.send_first       = send[0];
    o_res.send_second      = send[1];
    o_res.sent_id          = (send != 2'b00) ? own_id_r : '0;
    o_res.sent_count       = (send != 2'b00) ? own_cnt_r : '0;
    o_res.own_id           = own_id_nxt;
    o_res.own_count        = own_cnt_nxt;
    o_res.fast_from_first  = rx_fast_nxt[0];
    o_res.slow_from_first  = rx_slow_nxt[0];
    o_res.fast_from_second = rx_fast_nxt[1];
    o_res.slow_from_second = rx_slow_nxt[1];
    o_res.slow_to_first    = tx_slow_nxt[0];
    o_res.slow_to_second   = tx_slow_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_sync_r <= 1'b0;
      slow_lim_r  <= 10'd500;
      rec_lim_r   <= 10'd200;
      tick_r      <= '0;
      r10_r       <= '0;
      r100_r      <= '0;
      r150_r      <= '0;
      own_id_r    <= 32'd101;
      own_cnt_r   <= 32'd50;
      p1_id_r     <= NONE_ID;
      p1_cnt_r    <= NONE_ID;
      p2_id_r     <= NONE_ID;
      p2_cnt_r    <= NONE_ID;
      pend_r      <= '0;
      ivl_r[0]    <= '0;
      ivl_r[1]    <= '0;
      rx_fast_r   <= '0;
      rx_slow_r   <= '0;
      tx_slow_r   <= '0;
    end else begin
      tick_r    <= tick_nxt;
      r10_r     <= r10_nxt;
      r100_r    <= r100_nxt;
      r150_r    <= r150_nxt;
      p1_id_r   <= p1_id_nxt;
      p1_cnt_r  <= p1_cnt_nxt;
      p2_id_r   <= p2_id_nxt;
      p2_cnt_r  <= p2_cnt_nxt;
      pend_r    <= pend_nxt;
      ivl_r     <= ivl_nxt;
      rx_fast_r <= rx_fast_nxt;
      rx_slow_r <= rx_slow_nxt;
      tx_slow_r <= tx_slow_nxt;
      // writing an initial value loads the live register directly
      if (cfg_wr_en && cfg_index == CFG_INITIAL_ID) begin
        own_id_r <= cfg_data;
      end else begin
        own_id_r <= own_id_nxt;
      end
      if (cfg_wr_en && cfg_index == CFG_INITIAL_COUNT) begin
        own_cnt_r <= cfg_data;
      end else begin
        own_cnt_r <= own_cnt_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FAST_SYNC:      fast_sync_r <= cfg_data[0];
          CFG_TOO_SLOW_LIMIT: slow_lim_r  <= cfg_data[9:0];
          CFG_RECOVER_LIMIT:  rec_lim_r   <= cfg_data[9:0];
          default: begin
          end
        endcase
      end
    end
  end

  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    r10_r < 4'd10 && r100_r < 7'd100 && r150_r < 8'd150)
    else $error("tick residue out of range");

  a_ivl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ivl_r[0] <= 11'd1024 && ivl_r[1] <= 11'd1024)
    else $error("interval counter overflow");

  a_msg_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step && q_item.kind == K_MSG1 |=> pend_r[0])
    else $error("peer one message not marked pending");

  a_fast_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    step && q_item.kind == K_TICK && fast_sync_r |=> tx_slow_r == 2'b00)
    else $error("slow period chosen under fast sync");

endmodule

`default_nettype wire

[rtl/three_node_counter_sync.sv]
// ----------------------------------------------------------------------------
// three_node_counter_sync
// Node identity and count kept in step with two peers.
// ----------------------------------------------------------------------------
// Input channel: drive in_mode (tick, peer one or peer two message) with the
// peer identity and count, raise in_push; the transaction is taken on an edge
// where in_full is low. Every input transaction yields one result transaction
// on the out_ ports, read while out_empty is low and taken with out_pop.
// Configuration: cfg_wr_en with cfg_index and cfg_data, one register a cycle,
// issued only while no transaction is in flight; the user must see to this.
// Path: the input register loads on the input edge, the item is then written
// to the classified queue, and the state update writes the result queue.
// Throughput: one transaction per cycle while no queue stalls; a tick's state
// update is combinational, bounded by the adoption compare and max chain.
// Reset: own identity and count take their fixed reset values (101, 50),
// peer slots read as none, all flags and counters clear, both queues empty.
// Stall: when out_pop stays low the result queue fills, then the classified
// queue, then in_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module three_node_counter_sync (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_peer_id,
  input  wire logic [31:0] in_peer_count,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_send_first,
  output logic             out_send_second,
  output logic [31:0]      out_sent_id,
  output logic [31:0]      out_sent_count,
  output logic [31:0]      out_own_id,
  output logic [31:0]      out_own_count,
  output logic             out_fast_from_first,
  output logic             out_slow_from_first,
  output logic             out_fast_from_second,
  output logic             out_slow_from_second,
  output logic             out_slow_to_first,
  output logic             out_slow_to_second,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import tncs_pkg::*;

  qwr_t    f_wr, b_wr;
  item_t   f_item, q_item;
  logic    q_full, q_empty, q_pop, o_full;
  result_t b_res, o_res;

  tncs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_peer_id    (in_peer_id),
    .in_peer_count (in_peer_count),
    .q_wr          (f_wr),
    .q_full        (q_full),
    .q_item        (f_item)
  );

  tncs_fifo #(.W($bits(item_t))) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_wr.push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  tncs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .o_wr      (b_wr),
    .o_full    (o_full),
    .o_res     (b_res)
  );

  tncs_fifo #(.W($bits(result_t))) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_wr.push),
    .din   (b_res),
    .full  (o_full),
    .pop   (out_pop),
    .dout  (o_res),
    .empty (out_empty)
  );

  assign out_send_first       = o_res.send_first;
  assign out_send_second      = o_res.send_second;
  assign out_sent_id          = o_res.sent_id;
  assign out_sent_count       = o_res.sent_count;
  assign out_own_id           = o_res.own_id;
  assign out_own_count        = o_res.own_count;
  assign out_fast_from_first  = o_res.fast_from_first;
  assign out_slow_from_first  = o_res.slow_from_first;
  assign out_fast_from_second = o_res.fast_from_second;
  assign out_slow_from_second = o_res.slow_from_second;
  assign out_slow_to_first    = o_res.slow_to_first;
  assign out_slow_to_second   = o_res.slow_to_second;

endmodule

`default_nettype wire
